### design/msad_pkg.sv
// ----------------------------------------------------------------------------
// msad_pkg
// Shared constants and types of the sibling average downsampler.
// ----------------------------------------------------------------------------
package msad_pkg;

	localparam int COUNT_BITS   = 4;
	localparam int IDX_BITS     = 24;
	localparam int GUARD_BITS   = 3;
	localparam int CHILD_SHIFT  = 3;

	localparam logic [COUNT_BITS-1:0] MAX_SIBLINGS = 4'd8;

	// register index codes
	localparam logic REG_PARENT_BASE  = 1'b0;
	localparam logic REG_OUTPUT_START = 1'b1;

	// per-cycle commands to the component lanes
	typedef struct packed {
		logic clear;
		logic add;
		logic start;
	} lane_ctl_t;

endpackage

### design/msad_voxel_if.sv
// ----------------------------------------------------------------------------
// msad_voxel_if
// Child voxel channel: valid/ready with code, three components and end mark.
// ----------------------------------------------------------------------------
interface msad_voxel_if #(
	parameter int CODE_BITS  = 30,
	parameter int VALUE_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic        [CODE_BITS-1:0]  voxel_code;
	logic signed [VALUE_BITS-1:0] value_x;
	logic signed [VALUE_BITS-1:0] value_y;
	logic signed [VALUE_BITS-1:0] value_z;
	logic                         end_of_stream;

	modport source (
		output valid, voxel_code, value_x, value_y, value_z, end_of_stream,
		input  ready
	);
	modport sink (
		input  valid, voxel_code, value_x, value_y, value_z, end_of_stream,
		output ready
	);
endinterface

### design/msad_parent_if.sv
// ----------------------------------------------------------------------------
// msad_parent_if
// Parent result channel: valid/ready with code, averages and bookkeeping.
// ----------------------------------------------------------------------------
interface msad_parent_if #(
	parameter int CODE_BITS  = 30,
	parameter int VALUE_BITS = 16
);
	logic                                  valid;
	logic                                  ready;
	logic        [CODE_BITS-1:0]           parent_code;
	logic signed [VALUE_BITS-1:0]          avg_x;
	logic signed [VALUE_BITS-1:0]          avg_y;
	logic signed [VALUE_BITS-1:0]          avg_z;
	logic        [msad_pkg::COUNT_BITS-1:0] member_count;
	logic        [msad_pkg::IDX_BITS-1:0]   output_index;
	logic                                  overflow_error;
	logic                                  last_of_run;

	modport source (
		output valid, parent_code, avg_x, avg_y, avg_z, member_count,
		output output_index, overflow_error, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, parent_code, avg_x, avg_y, avg_z, member_count,
		input  output_index, overflow_error, last_of_run,
		output ready
	);
endinterface

### design/msad_lane.sv
// ----------------------------------------------------------------------------
// msad_lane
// One component lane: sibling accumulator and a radix-2 divider that takes
// the signed sum over the member count, truncated toward zero.
// ----------------------------------------------------------------------------
module msad_lane #(
	parameter int VALUE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  msad_pkg::lane_ctl_t                   ctl,
	input  logic signed [VALUE_BITS-1:0]          value,
	input  logic        [msad_pkg::COUNT_BITS-1:0] divisor,
	output logic signed [VALUE_BITS-1:0]          avg,
	output logic                                  done
);
	localparam int SUM_BITS = VALUE_BITS + msad_pkg::GUARD_BITS;
	localparam int STEP_BITS = $clog2(SUM_BITS + 1);
	localparam int REM_BITS = msad_pkg::COUNT_BITS - 1;

	logic signed [SUM_BITS-1:0]             sum_q;
	logic        [SUM_BITS-1:0]             mag_q;
	logic        [REM_BITS-1:0]             rem_q;
	logic        [msad_pkg::COUNT_BITS-1:0] div_q;
	logic                                   neg_q;
	logic        [STEP_BITS-1:0]            step_q;
	logic                                   busy_q;
	logic                                   done_q;

	logic        [msad_pkg::COUNT_BITS-1:0] trial;
	logic        [msad_pkg::COUNT_BITS-1:0] rem_next;
	logic                                   ge;
	logic        [SUM_BITS-1:0]             quo;

	// remainder stays below the divisor (at most 8), so it fits in three bits
	assign trial    = {rem_q, mag_q[SUM_BITS-1]};
	assign ge       = (trial >= div_q);
	assign rem_next = ge ? (trial - div_q) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= sum_q + {{msad_pkg::GUARD_BITS{value[VALUE_BITS-1]}}, value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_BITS'(SUM_BITS);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient bits shift in at the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mag_q <= sum_q[SUM_BITS-1] ? -sum_q : sum_q;
			neg_q <= sum_q[SUM_BITS-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			mag_q <= {mag_q[SUM_BITS-2:0], ge};
			rem_q <= rem_next[REM_BITS-1:0];
		end
	end

	assign quo  = neg_q ? -mag_q : mag_q;
	assign avg  = quo[VALUE_BITS-1:0];
	assign done = done_q;

endmodule

### design/morton_sibling_average_downsampler.sv
// ----------------------------------------------------------------------------
// morton_sibling_average_downsampler
// Groups Morton-ordered child voxels by parent and emits per-parent averages.
// ----------------------------------------------------------------------------
//  channel     direction  handshake       carries
//  voxel_in    in         valid/ready     voxel_code, value_x/y/z, end_of_stream
//  parent_out  out        valid/ready     parent_code, avg_x/y/z, member_count,
//                                         output_index, overflow_error, last_of_run
//  apb         in         psel/penable    parent_base (0), output_start (1)
//
//  A voxel is taken only in the idle state; one that causes no result passes through
//  the add state, and each result also runs the bit-serial divider in the three lanes.
//  Voxels are taken while a finished result still waits in the output register.
//  Reset clears the pending group, emitted count and both registers.
//  A stalled output holds the next result in the divider until the register frees.
// ----------------------------------------------------------------------------
module morton_sibling_average_downsampler #(
	parameter int CODE_BITS  = 30,
	parameter int VALUE_BITS = 16,
	localparam int PDATA_BITS = (CODE_BITS > 32) ? 64 : 32,
	localparam int PADDR_BITS = (CODE_BITS > 32) ? 4 : 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	msad_voxel_if.sink            voxel_in,
	msad_parent_if.source         parent_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);
	localparam int CB = msad_pkg::COUNT_BITS;
	localparam int IB = msad_pkg::IDX_BITS;
	localparam int NUM_LANES = 3;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]           state_q;
	logic [CODE_BITS-1:0] parent_base_q;
	logic [IB-1:0]        output_start_q;
	logic [IB-1:0]        emitted_q;
	logic [CODE_BITS-1:0] group_parent_q;
	logic [CB-1:0]        group_count_q;

	// accepted voxel
	logic [CODE_BITS-1:0]  item_parent_q;
	logic                  item_eos_q;
	logic [VALUE_BITS-1:0] item_val_q [NUM_LANES];
	logic                  added_q;
	logic                  ovf_q;
	logic                  last_q;

	// output register
	logic                  out_valid_q;
	logic [CODE_BITS-1:0]  out_parent_q;
	logic [VALUE_BITS-1:0] out_avg_q [NUM_LANES];
	logic [CB-1:0]         out_count_q;
	logic [IB-1:0]         out_index_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	msad_pkg::lane_ctl_t   lane_ctl;
	logic [VALUE_BITS-1:0] lane_avg [NUM_LANES];
	logic [NUM_LANES-1:0]  lane_done;

	logic cfg_wr;
	logic reg_sel;
	logic in_xfer;
	logic out_free;
	logic need_flush;
	logic load_out;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[PADDR_BITS-1];

	always_comb begin
		case (reg_sel)
			msad_pkg::REG_PARENT_BASE:  prdata = PDATA_BITS'(parent_base_q);
			msad_pkg::REG_OUTPUT_START: prdata = PDATA_BITS'(output_start_q);
			default:                    prdata = '0;
		endcase
	end

	assign voxel_in.ready = (state_q == ST_IDLE);
	assign in_xfer        = voxel_in.valid && voxel_in.ready;
	assign out_free       = !out_valid_q || parent_out.ready;
	assign load_out       = (state_q == ST_OUT) && out_free;

	assign need_flush = (group_count_q != '0) &&
		((item_parent_q != group_parent_q) || (group_count_q == msad_pkg::MAX_SIBLINGS));

	always_comb begin
		lane_ctl = '0;
		if (state_q == ST_ADD) begin
			if (added_q || need_flush) begin
				lane_ctl.start = 1'b1;
			end else begin
				lane_ctl.add = 1'b1;
			end
		end
		if (load_out) begin
			lane_ctl.clear = 1'b1;
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		msad_lane #(
			.VALUE_BITS(VALUE_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.value   (item_val_q[i]),
			.divisor (group_count_q),
			.avg     (lane_avg[i]),
			.done    (lane_done[i])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_base_q  <= '0;
			output_start_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				msad_pkg::REG_PARENT_BASE:  parent_base_q  <= pwdata[CODE_BITS-1:0];
				msad_pkg::REG_OUTPUT_START: output_start_q <= pwdata[IB-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			emitted_q      <= '0;
			group_parent_q <= '0;
			group_count_q  <= '0;
			added_q        <= 1'b0;
			ovf_q          <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			if (cfg_wr && (reg_sel == msad_pkg::REG_OUTPUT_START)) begin
				emitted_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						added_q <= 1'b0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (added_q) begin
						// end of stream: flush the group that now holds this voxel
						ovf_q   <= 1'b0;
						last_q  <= 1'b1;
						state_q <= ST_DIV;
					end else if (need_flush) begin
						ovf_q   <= (item_parent_q == group_parent_q);
						last_q  <= !item_eos_q;
						state_q <= ST_DIV;
					end else begin
						if (group_count_q == '0) begin
							group_parent_q <= item_parent_q;
						end
						group_count_q <= group_count_q + 1'b1;
						added_q       <= 1'b1;
						state_q       <= item_eos_q ? ST_ADD : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (&lane_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						group_count_q <= '0;
						emitted_q     <= emitted_q + 1'b1;
						state_q       <= added_q ? ST_IDLE : ST_ADD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, parent computed on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_parent_q <= parent_base_q + (voxel_in.voxel_code >> msad_pkg::CHILD_SHIFT);
			item_eos_q    <= voxel_in.end_of_stream;
			item_val_q[0] <= voxel_in.value_x;
			item_val_q[1] <= voxel_in.value_y;
			item_val_q[2] <= voxel_in.value_z;
		end
	end

	// merge the lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (parent_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_parent_q <= group_parent_q;
			out_avg_q[0] <= lane_avg[0];
			out_avg_q[1] <= lane_avg[1];
			out_avg_q[2] <= lane_avg[2];
			out_count_q  <= group_count_q;
			out_index_q  <= output_start_q + emitted_q;
			out_ovf_q    <= ovf_q;
			out_last_q   <= last_q;
		end
	end

	assign parent_out.valid          = out_valid_q;
	assign parent_out.parent_code    = out_parent_q;
	assign parent_out.avg_x          = out_avg_q[0];
	assign parent_out.avg_y          = out_avg_q[1];
	assign parent_out.avg_z          = out_avg_q[2];
	assign parent_out.member_count   = out_count_q;
	assign parent_out.output_index   = out_index_q;
	assign parent_out.overflow_error = out_ovf_q;
	assign parent_out.last_of_run    = out_last_q;

endmodule
